>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the block.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/bssd_pkg.sv
// Types and constants of the bank-switch / soft-switch decoder.
// No dependencies; used by the decode logic, the top level and the checker.
package bssd_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;

  localparam logic [3:0] TGT_NONE   = 4'd0;
  localparam logic [3:0] TGT_MAIN   = 4'd1;
  localparam logic [3:0] TGT_AUX    = 4'd2;
  localparam logic [3:0] TGT_LCMAIN = 4'd3;
  localparam logic [3:0] TGT_LCAUX  = 4'd4;
  localparam logic [3:0] TGT_ROM    = 4'd5;
  localparam logic [3:0] TGT_PROM   = 4'd6;
  localparam logic [3:0] TGT_DISK   = 4'd7;
  localparam logic [3:0] TGT_REG    = 4'd8;

  localparam logic CFG_ENHANCED  = 1'b0;
  localparam logic CFG_DISK_PROM = 1'b1;

  // video switch bits
  localparam int unsigned VB_TEXT  = 0;
  localparam int unsigned VB_MIXED = 1;
  localparam int unsigned VB_PAGE2 = 2;
  localparam int unsigned VB_HIRES = 3;

  // aux switch bits
  localparam int unsigned XB_STORE80 = 0;
  localparam int unsigned XB_RAMRD   = 1;
  localparam int unsigned XB_RAMWRT  = 2;
  localparam int unsigned XB_INTCX   = 3;
  localparam int unsigned XB_ALTZP   = 4;
  localparam int unsigned XB_SLOTC3  = 5;
  localparam int unsigned XB_COL80   = 6;
  localparam int unsigned XB_ALTCHR  = 7;

  // language-card flag bits
  localparam int unsigned LB_READ  = 0;
  localparam int unsigned LB_WRITE = 1;
  localparam int unsigned LB_BANK2 = 2;
  localparam int unsigned LB_PRE   = 3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [6:0]  key_code;
    logic        any_key_down;
    logic        in_vblank;
    logic        open_apple;
    logic        closed_apple;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        write_enable;
    logic [7:0]  reg_data;
    logic        speaker;
    logic        text_mode;
    logic        mixed_mode;
    logic        display_page2;
    logic        hires_mode;
    logic        col80_mode;
    logic        alt_charset;
    logic        double_hires;
  } out_item_t;

  typedef struct packed {
    logic enhanced_model;
    logic disk_prom_present;
  } bssd_cfg_t;

  typedef struct packed {
    logic [3:0] video;
    logic [7:0] aux;
    logic       ann3;
    logic       c8_rom_on;
    logic [3:0] lc;
    logic       speaker;
    logic [7:0] key_latch;
  } bssd_state_t;

  localparam bssd_state_t STATE_RESET = '{
    video:     4'b0001,
    aux:       8'h00,
    ann3:      1'b1,
    c8_rom_on: 1'b0,
    lc:        4'b0100,
    speaker:   1'b0,
    key_latch: 8'h00
  };

endpackage

>>> hdl/bank_switch_soft_switch_decoder.sv
// Top level of the bank-switch / soft-switch decoder: input register, switch
// state, result register and configuration registers. Depends on bssd_pkg, bssd_decode.
//
// Takes one bus access or key event per transfer and returns one result per
// transfer. An item is registered on entry, decoded in a single pass against the
// switch state and registered at the output, so the block accepts one item every
// clock while the output is not stalled, and its result is presented from the
// result register. The input side stalls only while the input register holds an
// item and the result register is full and stalled. Configuration writes are
// registered and are meant for idle periods.
module bank_switch_soft_switch_decoder import bssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_wdata
);

  logic        in_v_r;
  in_item_t    in_r;
  logic        out_v_r;
  out_item_t   out_r;
  bssd_state_t st_r, st_nxt;
  bssd_cfg_t   cfg_r;
  out_item_t   res;
  logic        advance;

  bssd_decode u_decode (
    .item   (in_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance   = in_v_r & (~out_v_r | ~out_stall);
  assign in_stall  = in_v_r & out_v_r & out_stall;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= STATE_RESET;
      cfg_r   <= '0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENHANCED:  cfg_r.enhanced_model    <= cfg_wdata;
          CFG_DISK_PROM: cfg_r.disk_prom_present <= cfg_wdata;
          default:       cfg_r <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_item;
    if (advance) out_r <= res;
  end

endmodule

>>> hdl/bssd_decode.sv
// Combinational decode of one bus access or key event against the switch state.
// Depends on bssd_pkg.
module bssd_decode import bssd_pkg::*; (
  input  in_item_t    item,
  input  bssd_state_t st,
  input  bssd_cfg_t   cfg,
  output bssd_state_t st_nxt,
  output out_item_t   res
);

  function automatic logic [7:0] flag80(logic b);
    return {b, 7'h00};
  endfunction

  function automatic logic [3:0] lc_touch(logic [3:0] f, logic [3:0] n);
    logic [3:0] g;
    g = f;
    g[LB_BANK2] = ~n[3];
    g[LB_READ]  = (n[1:0] == 2'd0) || (n[1:0] == 2'd3);
    if (n[0]) begin
      if (f[LB_PRE]) g[LB_WRITE] = 1'b1;
      g[LB_PRE] = 1'b1;
    end else begin
      g[LB_WRITE] = 1'b0;
      g[LB_PRE]   = 1'b0;
    end
    return g;
  endfunction

  // speaker, video and annunciator switches hit by both reads and writes
  function automatic bssd_state_t common_sw(bssd_state_t s, logic [7:0] a);
    bssd_state_t t;
    t = s;
    case (a) inside
      8'h30:          t.speaker = ~s.speaker;
      [8'h50:8'h57]:  t.video[a[2:1]] = a[0];
      8'h5E:          t.ann3 = 1'b0;
      8'h5F:          t.ann3 = 1'b1;
      default:        t = s;
    endcase
    return t;
  endfunction

  logic [15:0] addr;
  logic [7:0]  a;
  logic        iie;
  logic        hi_c000, io_page, cx_page, zp_low, in_text, in_hires;
  logic        vid_aux, ram_aux_rd, ram_aux_wr, lc_aux, lc_bank_hit, c3;
  logic [3:0]  lc_tgt;
  logic [15:0] lc_off, rom_off;
  logic [3:0]  tgt;
  logic [15:0] off;
  logic        we;
  logic [7:0]  rdata;
  logic        col80;

  assign addr     = item.address;
  assign a        = addr[7:0];
  assign iie      = cfg.enhanced_model;
  assign hi_c000  = addr[15:14] == 2'b11;
  assign io_page  = addr[15:8] == 8'hC0;
  assign cx_page  = addr[15:12] == 4'hC;
  assign zp_low   = addr[15:9] == 7'd0;
  assign in_text  = addr[15:10] == 6'b000001;
  assign in_hires = addr[15:13] == 3'b001;
  assign c3       = addr[15:8] == 8'hC3;
  assign rom_off  = {2'b00, addr[13:0]};

  assign vid_aux = iie & st.aux[XB_STORE80] & (in_text | (st.video[VB_HIRES] & in_hires));
  assign ram_aux_rd = zp_low ? (iie & st.aux[XB_ALTZP]) :
                      vid_aux ? st.video[VB_PAGE2] : (iie & st.aux[XB_RAMRD]);
  assign ram_aux_wr = zp_low ? (iie & st.aux[XB_ALTZP]) :
                      vid_aux ? st.video[VB_PAGE2] : (iie & st.aux[XB_RAMWRT]);

  assign lc_aux      = iie & st.aux[XB_ALTZP];
  assign lc_bank_hit = (addr[15:12] == 4'hD) & st.lc[LB_BANK2];
  assign lc_tgt = lc_bank_hit ? (lc_aux ? TGT_LCAUX : TGT_LCMAIN) :
                                (lc_aux ? TGT_AUX : TGT_MAIN);
  assign lc_off = lc_bank_hit ? {4'h0, addr[11:0]} : addr;

  always_comb begin
    st_nxt = st;
    tgt    = TGT_NONE;
    off    = '0;
    we     = 1'b0;
    rdata  = '0;
    unique case (item.opcode)
      OP_READ: begin
        if (!hi_c000) begin
          tgt = ram_aux_rd ? TGT_AUX : TGT_MAIN;
          off = addr;
        end else if (io_page) begin
          tgt = TGT_REG;
          unique case (a) inside
            [8'hE0:8'hEF]: begin
              tgt = TGT_DISK;
              off = {8'h00, a};
            end
            [8'h80:8'h8F]: st_nxt.lc = lc_touch(st.lc, a[3:0]);
            8'h19: rdata = flag80(item.in_vblank);
            8'h61: rdata = flag80(item.open_apple);
            8'h62: rdata = flag80(item.closed_apple);
            8'h00: rdata = st.key_latch;
            8'h10: begin
              st_nxt.key_latch[7] = 1'b0;
              rdata = iie ? {item.any_key_down, st.key_latch[6:0]} : st.key_latch;
            end
            8'h11: rdata = flag80(st.lc[LB_BANK2]);
            8'h12: rdata = flag80(st.lc[LB_READ]);
            8'h13: rdata = flag80(st.aux[XB_RAMRD]);
            8'h14: rdata = flag80(st.aux[XB_RAMWRT]);
            8'h15: rdata = flag80(st.aux[XB_INTCX]);
            8'h16: rdata = flag80(st.aux[XB_ALTZP]);
            8'h17: rdata = flag80(st.aux[XB_SLOTC3]);
            8'h18: rdata = flag80(st.aux[XB_STORE80]);
            8'h1A: rdata = flag80(st.video[VB_TEXT]);
            8'h1B: rdata = flag80(st.video[VB_MIXED]);
            8'h1C: rdata = flag80(st.video[VB_PAGE2]);
            8'h1D: rdata = flag80(st.video[VB_HIRES]);
            8'h1E: rdata = flag80(st.aux[XB_ALTCHR]);
            8'h1F: rdata = flag80(st.aux[XB_COL80]);
            default: st_nxt = common_sw(st, a);
          endcase
        end else if (cx_page) begin
          tgt = TGT_REG;
          if (addr == 16'hCFFF) begin
            st_nxt.c8_rom_on = 1'b0;
            if (iie) begin
              tgt = TGT_ROM;
              off = rom_off;
            end
          end else if (iie && st.aux[XB_INTCX]) begin
            if (c3) st_nxt.c8_rom_on = 1'b1;
            tgt = TGT_ROM;
            off = rom_off;
          end else if (iie && c3 && !st.aux[XB_SLOTC3]) begin
            st_nxt.c8_rom_on = 1'b1;
            tgt = TGT_ROM;
            off = rom_off;
          end else if (addr[11]) begin
            if (iie && st.c8_rom_on) begin
              tgt = TGT_ROM;
              off = rom_off;
            end
          end else if (addr[11:8] == 4'h6 && cfg.disk_prom_present) begin
            tgt = TGT_PROM;
            off = {8'h00, a};
          end
        end else if (st.lc[LB_READ]) begin
          tgt = lc_tgt;
          off = lc_off;
        end else begin
          tgt = TGT_ROM;
          off = rom_off;
        end
      end
      OP_WRITE: begin
        if (!hi_c000) begin
          tgt = ram_aux_wr ? TGT_AUX : TGT_MAIN;
          off = addr;
          we  = 1'b1;
        end else if (io_page) begin
          unique case (a) inside
            [8'hE0:8'hEF]: begin
              tgt = TGT_DISK;
              off = {8'h00, a};
              we  = 1'b1;
            end
            [8'h80:8'h8F]: st_nxt.lc = lc_touch(st.lc, a[3:0]);
            [8'h00:8'h0F]: begin
              if (iie) st_nxt.aux[a[3:1]] = a[0];
            end
            8'h10:   st_nxt.key_latch[7] = 1'b0;
            default: st_nxt = common_sw(st, a);
          endcase
        end else if (cx_page) begin
          if (addr == 16'hCFFF) st_nxt.c8_rom_on = 1'b0;
        end else if (st.lc[LB_WRITE]) begin
          tgt = lc_tgt;
          off = lc_off;
          we  = 1'b1;
        end
      end
      OP_KEY: begin
        if (item.key_code != 7'd0) st_nxt.key_latch = {1'b1, item.key_code};
      end
      default: st_nxt = st;
    endcase
  end

  assign col80 = st_nxt.aux[XB_COL80];

  always_comb begin
    res.target        = tgt;
    res.offset        = off;
    res.write_enable  = we;
    res.reg_data      = (tgt == TGT_REG) ? rdata : 8'h00;
    res.speaker       = st_nxt.speaker;
    res.text_mode     = st_nxt.video[VB_TEXT];
    res.mixed_mode    = st_nxt.video[VB_MIXED];
    res.display_page2 = st_nxt.video[VB_PAGE2] & ~st_nxt.aux[XB_STORE80] & ~col80;
    res.hires_mode    = st_nxt.video[VB_HIRES];
    res.col80_mode    = col80;
    res.alt_charset   = st_nxt.aux[XB_ALTCHR];
    res.double_hires  = iie & ~st_nxt.ann3 & col80;
  end

endmodule

>>> hdl/bssd_checker.sv
// Port-level checks of the decoder's result channel, bound to the top level.
// Depends on bssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bssd_checker import bssd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `BSSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `BSSD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))
  `BSSD_ASSERT_NOW(a_data_only_reg, out_valid && out_item.target != TGT_REG, out_item.reg_data == 8'h00)
  `BSSD_ASSERT_NOW(a_dhires_col80, out_valid && out_item.double_hires, out_item.col80_mode && !out_item.display_page2)

endmodule

bind bank_switch_soft_switch_decoder bssd_checker u_bssd_checker (.*);

>>> dv/bank_switch_soft_switch_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bank_switch_soft_switch_decoder: directed and random bus traffic
// with random gaps and output stalls, checked against a cycle-free predictor of the switches.
// Depends on bssd_pkg and the top level only.
module bank_switch_soft_switch_decoder_test;
  import bssd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 312;
  localparam int STUCK_LIMIT = 2000;

  // key events carry their key code in the low address bits
  localparam logic [17:0] PROBES [25] = '{
    {OP_READ, 16'h0000}, {OP_WRITE, 16'hFFFF}, {OP_KEY, 16'h007F}, {OP_KEY, 16'h0000},
    {OP_READ, 16'hC000}, {OP_READ, 16'hC010}, {OP_UNUSED, 16'hC030}, {OP_READ, 16'hC030},
    {OP_WRITE, 16'hC00D}, {OP_WRITE, 16'hC05E}, {OP_READ, 16'hC081}, {OP_WRITE, 16'hC081},
    {OP_WRITE, 16'hD000}, {OP_READ, 16'hC08B}, {OP_READ, 16'hD123}, {OP_READ, 16'hC0E5},
    {OP_WRITE, 16'hC0EF}, {OP_READ, 16'hC07F}, {OP_READ, 16'hC300}, {OP_READ, 16'hC800},
    {OP_WRITE, 16'hCFFF}, {OP_READ, 16'hC800}, {OP_READ, 16'hC600}, {OP_WRITE, 16'hC009},
    {OP_READ, 16'h01FF}
  };

  class switch_scoreboard;
    bit         enhanced;
    bit         prom_mapped;
    logic [3:0] video;
    logic [7:0] aux;
    logic       ann3;
    logic       c8_rom;
    logic       speaker;
    logic [3:0] lc;
    logic [7:0] key_latch;
    out_item_t  res;
    out_item_t  expected_decodes[$];
    int         errors;

    function new();
      enhanced    = 1'b0;
      prom_mapped = 1'b0;
      video       = STATE_RESET.video;
      aux         = STATE_RESET.aux;
      ann3        = STATE_RESET.ann3;
      c8_rom      = STATE_RESET.c8_rom_on;
      speaker     = STATE_RESET.speaker;
      lc          = STATE_RESET.lc;
      key_latch   = STATE_RESET.key_latch;
      errors      = 0;
    endfunction

    function void set_config(logic idx, logic val);
      if (idx == CFG_ENHANCED) enhanced = val;
      else prom_mapped = val;
    endfunction

    function void give(logic [3:0] tgt, logic [15:0] off, logic we, logic [7:0] data);
      res.target       = tgt;
      res.offset       = off;
      res.write_enable = we;
      res.reg_data     = data;
    endfunction

    function logic [7:0] flag(logic c);
      return {c, 7'h00};
    endfunction

    function void lc_touch(logic [3:0] n);
      lc[LB_BANK2] = !n[3];
      lc[LB_READ]  = (n[1:0] == 2'd0) || (n[1:0] == 2'd3);
      if (n[0]) begin
        if (lc[LB_PRE]) lc[LB_WRITE] = 1'b1;
        lc[LB_PRE] = 1'b1;
      end else begin
        lc[LB_WRITE] = 1'b0;
        lc[LB_PRE]   = 1'b0;
      end
    endfunction

    function void common_switch(logic [7:0] a);
      if (a == 8'h30) speaker = ~speaker;
      else if (a >= 8'h50 && a <= 8'h57) video[a[2:1]] = a[0];
      else if (a == 8'h5E) ann3 = 1'b0;
      else if (a == 8'h5F) ann3 = 1'b1;
    endfunction

    function logic [7:0] io_read(logic [7:0] a, logic anykey);
      logic [7:0] s;
      case (a)
        8'h00: return key_latch;
        8'h10: begin
          s = key_latch;
          key_latch[7] = 1'b0;
          return enhanced ? {anykey, s[6:0]} : s;
        end
        8'h11: return flag(lc[LB_BANK2]);
        8'h12: return flag(lc[LB_READ]);
        8'h13: return flag(aux[XB_RAMRD]);
        8'h14: return flag(aux[XB_RAMWRT]);
        8'h15: return flag(aux[XB_INTCX]);
        8'h16: return flag(aux[XB_ALTZP]);
        8'h17: return flag(aux[XB_SLOTC3]);
        8'h18: return flag(aux[XB_STORE80]);
        8'h1A: return flag(video[VB_TEXT]);
        8'h1B: return flag(video[VB_MIXED]);
        8'h1C: return flag(video[VB_PAGE2]);
        8'h1D: return flag(video[VB_HIRES]);
        8'h1E: return flag(aux[XB_ALTCHR]);
        8'h1F: return flag(aux[XB_COL80]);
        default: ;
      endcase
      common_switch(a);
      return 8'h00;
    endfunction

    function void ram_target(logic [15:0] addr, logic wr);
      logic alt;
      if (addr < 16'h0200) alt = enhanced && aux[XB_ALTZP];
      else begin
        alt = enhanced && (wr ? aux[XB_RAMWRT] : aux[XB_RAMRD]);
        if (enhanced && aux[XB_STORE80]) begin
          if (addr >= 16'h0400 && addr < 16'h0800) alt = video[VB_PAGE2];
          else if (video[VB_HIRES] && addr >= 16'h2000 && addr < 16'h4000)
            alt = video[VB_PAGE2];
        end
      end
      give(alt ? TGT_AUX : TGT_MAIN, addr, wr, 8'h00);
    endfunction

    function void lc_target(logic [15:0] addr, logic wr);
      logic alt;
      alt = enhanced && aux[XB_ALTZP];
      if (addr < 16'hE000 && lc[LB_BANK2])
        give(alt ? TGT_LCAUX : TGT_LCMAIN, addr - 16'hD000, wr, 8'h00);
      else
        give(alt ? TGT_AUX : TGT_MAIN, addr, wr, 8'h00);
    endfunction

    function void cx_read(logic [15:0] addr);
      logic c3;
      c3 = (addr[15:8] == 8'hC3);
      if (addr == 16'hCFFF) begin
        c8_rom = 1'b0;
        if (enhanced) give(TGT_ROM, addr - 16'hC000, 1'b0, 8'h00);
        else give(TGT_REG, 16'h0000, 1'b0, 8'h00);
      end else if (enhanced && aux[XB_INTCX]) begin
        if (c3) c8_rom = 1'b1;
        give(TGT_ROM, addr - 16'hC000, 1'b0, 8'h00);
      end else if (enhanced && c3 && !aux[XB_SLOTC3]) begin
        c8_rom = 1'b1;
        give(TGT_ROM, addr - 16'hC000, 1'b0, 8'h00);
      end else if (addr >= 16'hC800) begin
        if (enhanced && c8_rom) give(TGT_ROM, addr - 16'hC000, 1'b0, 8'h00);
        else give(TGT_REG, 16'h0000, 1'b0, 8'h00);
      end else if (addr[11:8] == 4'h6 && prom_mapped)
        give(TGT_PROM, {8'h00, addr[7:0]}, 1'b0, 8'h00);
      else
        give(TGT_REG, 16'h0000, 1'b0, 8'h00);
    endfunction

    function void bus_read(in_item_t it);
      logic [7:0] a;
      a = it.address[7:0];
      if (it.address < 16'hC000) ram_target(it.address, 1'b0);
      else if (it.address < 16'hC100) begin
        if (a >= 8'hE0 && a <= 8'hEF) give(TGT_DISK, {8'h00, a}, 1'b0, 8'h00);
        else if (a >= 8'h80 && a <= 8'h8F) begin
          lc_touch(a[3:0]);
          give(TGT_REG, 16'h0000, 1'b0, 8'h00);
        end
        else if (a == 8'h19) give(TGT_REG, 16'h0000, 1'b0, flag(it.in_vblank));
        else if (a == 8'h61) give(TGT_REG, 16'h0000, 1'b0, flag(it.open_apple));
        else if (a == 8'h62) give(TGT_REG, 16'h0000, 1'b0, flag(it.closed_apple));
        else give(TGT_REG, 16'h0000, 1'b0, io_read(a, it.any_key_down));
      end
      else if (it.address < 16'hD000) cx_read(it.address);
      else if (lc[LB_READ]) lc_target(it.address, 1'b0);
      else give(TGT_ROM, it.address - 16'hC000, 1'b0, 8'h00);
    endfunction

    function void bus_write(logic [15:0] addr);
      logic [7:0] a;
      a = addr[7:0];
      if (addr < 16'hC000) ram_target(addr, 1'b1);
      else if (addr < 16'hC100) begin
        if (a >= 8'hE0 && a <= 8'hEF) give(TGT_DISK, {8'h00, a}, 1'b1, 8'h00);
        else if (a >= 8'h80 && a <= 8'h8F) lc_touch(a[3:0]);
        else if (a <= 8'h0F) begin
          if (enhanced) aux[a[3:1]] = a[0];
        end
        else if (a == 8'h10) key_latch[7] = 1'b0;
        else common_switch(a);
      end
      else if (addr < 16'hD000) begin
        if (addr == 16'hCFFF) c8_rom = 1'b0;
      end
      else if (lc[LB_WRITE]) lc_target(addr, 1'b1);
    endfunction

    function void note_input(in_item_t it);
      res = '0;
      case (it.opcode)
        OP_READ:  bus_read(it);
        OP_WRITE: bus_write(it.address);
        OP_KEY:   if (it.key_code != 7'd0) key_latch = {1'b1, it.key_code};
        default: ;
      endcase
      res.speaker       = speaker;
      res.text_mode     = video[VB_TEXT];
      res.mixed_mode    = video[VB_MIXED];
      res.display_page2 = video[VB_PAGE2] && !aux[XB_STORE80] && !aux[XB_COL80];
      res.hires_mode    = video[VB_HIRES];
      res.col80_mode    = aux[XB_COL80];
      res.alt_charset   = aux[XB_ALTCHR];
      res.double_hires  = enhanced && !ann3 && aux[XB_COL80];
      expected_decodes.insert(expected_decodes.size(), res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_decodes.size() == 0) begin
        report("result transfer with no decode pending");
        return;
      end
      want = expected_decodes.pop_front();
      field("target", 16'(got.target), 16'(want.target));
      field("offset", got.offset, want.offset);
      field("write_enable", 16'(got.write_enable), 16'(want.write_enable));
      field("reg_data", 16'(got.reg_data), 16'(want.reg_data));
      field("speaker", 16'(got.speaker), 16'(want.speaker));
      field("text_mode", 16'(got.text_mode), 16'(want.text_mode));
      field("mixed_mode", 16'(got.mixed_mode), 16'(want.mixed_mode));
      field("display_page2", 16'(got.display_page2), 16'(want.display_page2));
      field("hires_mode", 16'(got.hires_mode), 16'(want.hires_mode));
      field("col80_mode", 16'(got.col80_mode), 16'(want.col80_mode));
      field("alt_charset", 16'(got.alt_charset), 16'(want.alt_charset));
      field("double_hires", 16'(got.double_hires), 16'(want.double_hires));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic      cfg_wdata = 1'b0;
  bit        quiet = 1'b0;
  int        stuck;

  switch_scoreboard sb = new();

  bank_switch_soft_switch_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin : watchdog
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("bank_switch_soft_switch_decoder verification failed");
    $finish;
  end

  function automatic in_item_t with_noise(logic [1:0] op, logic [15:0] addr);
    in_item_t it;
    it.opcode       = op;
    it.address      = addr;
    it.write_data   = 8'($urandom);
    it.key_code     = 7'($urandom);
    it.any_key_down = 1'($urandom);
    it.in_vblank    = 1'($urandom);
    it.open_apple   = 1'($urandom);
    it.closed_apple = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_access();
    int         pick;
    logic [1:0] op;
    logic [15:0] addr;
    pick = $urandom_range(99);
    op = $urandom_range(1) ? OP_WRITE : OP_READ;
    addr = 16'($urandom);
    if (pick < 16) begin
      case ($urandom_range(3))
        0: addr = 16'($urandom_range(16'h01FF));
        1: addr = 16'($urandom_range(16'h07FF, 16'h0400));
        2: addr = 16'($urandom_range(16'h3FFF, 16'h2000));
        default: addr = 16'($urandom_range(16'hBFFF));
      endcase
    end else if (pick < 28) begin
      op = OP_WRITE;
      addr = 16'hC000 + 16'($urandom_range(15));
    end else if (pick < 40) begin
      case ($urandom_range(4))
        0: addr = 16'hC000 + 16'($urandom_range(8'h1F, 8'h10));
        1: addr = 16'hC000 + 16'($urandom_range(8'h5F, 8'h50));
        2: addr = 16'hC030;
        3: addr = 16'hC000;
        default: addr = 16'hC060 + 16'($urandom_range(2));
      endcase
      if ($urandom_range(3) == 0) addr = 16'hC019;
    end else if (pick < 50) begin
      addr = 16'hC000 + 16'($urandom_range(255));
    end else if (pick < 62) begin
      op = ($urandom_range(3) == 0) ? OP_WRITE : OP_READ;
      case ($urandom_range(4))
        0: addr = 16'($urandom_range(16'hC3FF, 16'hC300));
        1: addr = 16'($urandom_range(16'hC6FF, 16'hC600));
        2: addr = 16'($urandom_range(16'hCFFF, 16'hC800));
        3: addr = 16'hCFFF;
        default: addr = 16'($urandom_range(16'hCFFF, 16'hC100));
      endcase
    end else if (pick < 80) begin
      addr = 16'($urandom_range(16'hFFFF, 16'hD000));
    end else if (pick < 88) begin
      op = OP_KEY;
    end else if (pick < 90) begin
      op = OP_UNUSED;
    end else begin
      op = 2'($urandom_range(3));
    end
    return with_noise(op, addr);
  endfunction

  task automatic send(input in_item_t it);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic enh, input logic prom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENHANCED;
    cfg_wdata <= enh;
    @(posedge clk);
    cfg_index <= CFG_DISK_PROM;
    cfg_wdata <= prom;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(CFG_ENHANCED, enh);
    sb.set_config(CFG_DISK_PROM, prom);
  endtask

  task automatic directed();
    in_item_t it;
    foreach (PROBES[i]) begin
      it = with_noise(PROBES[i][17:16], PROBES[i][15:0]);
      if (it.opcode == OP_KEY) it.key_code = PROBES[i][6:0];
      send(it);
    end
  endtask

  initial begin : stimulus
    in_item_t    it;
    int          sent;
    logic [15:0] lc_addr;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b1, 1'b1);
    directed();
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_mode(ph[0], ph[1]);
      quiet <= (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 12) begin
          // language-card switch hit twice, then traffic into the card's range
          lc_addr = 16'hC080 + 16'($urandom_range(15));
          if ($urandom_range(9) < 7) lc_addr[0] = 1'b1;
          repeat (2) send(with_noise($urandom_range(1) ? OP_WRITE : OP_READ, lc_addr));
          repeat (2) send(with_noise($urandom_range(1) ? OP_WRITE : OP_READ,
                                     16'($urandom_range(16'hFFFF, 16'hD000))));
          sent += 4;
        end else begin
          it = random_access();
          if ($urandom_range(7) == 0) it.key_code = 7'd0;
          send(it);
          sent++;
        end
      end
    end
    drain();
    if (sb.errors == 0) $display("bank_switch_soft_switch_decoder verification clean");
    else $display("bank_switch_soft_switch_decoder verification failed");
    $finish;
  end

endmodule

>>> bank_switch_soft_switch_decoder.f
+incdir+hdl
hdl/bssd_pkg.sv
hdl/bssd_decode.sv
hdl/bank_switch_soft_switch_decoder.sv
hdl/bssd_checker.sv
dv/bank_switch_soft_switch_decoder_test.sv
